/* design/xor_parity_fec_decoder_defines.svh */
// Assertion helpers shared by the decoder files.
`ifndef XOR_PARITY_FEC_DECODER_DEFINES_SVH
`define XOR_PARITY_FEC_DECODER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define XFEC_ASSERT_IMPL(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("xfec: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define XFEC_ASSERT_NEXT(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("xfec: next-cycle check failed");

`endif

/* design/xfec_pkg.sv */
package xfec_pkg;

	localparam int GROUP_SIZE      = 8;
	localparam int SLOT_W          = $clog2(GROUP_SIZE);
	localparam int DATA_SLOTS      = GROUP_SIZE - 1;
	localparam int FRAME_WORDS_DEF = 256;

	localparam int SEQ_W    = 16;
	localparam int IDX_W    = 8;
	localparam int WORD_W   = 32;
	localparam int CNT_W    = 32;
	localparam int STATUS_W = 2;
	localparam int GRP_W    = SEQ_W - SLOT_W;

	localparam logic [SLOT_W-1:0] PARITY_SLOT = SLOT_W'(GROUP_SIZE - 1);

	// result status
	localparam logic [STATUS_W-1:0] ST_PASS    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REBUILT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FAIL    = 2'd2;

	// outcome of the latest parity word 0, cleared by any data word
	localparam logic [1:0] OC_NONE    = 2'd0;
	localparam logic [1:0] OC_REBUILD = 2'd1;
	localparam logic [1:0] OC_FAIL    = 2'd2;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq_number;
		logic [IDX_W-1:0]  word_index;
		logic [WORD_W-1:0] data_word;
	} xfec_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   out_word;
		logic [SLOT_W-1:0]   out_slot;
		logic                out_last;
		logic [CNT_W-1:0]    recovered_total;
		logic [CNT_W-1:0]    failed_total;
	} xfec_out_t;

	typedef struct packed {
		logic                store;
		logic                emit;
		logic                rebuild;
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic                last;
		logic [CNT_W-1:0]    recovered;
		logic [CNT_W-1:0]    failed;
	} xfec_ctrl_t;

endpackage

/* design/xfec_slot_ram.sv */
module xfec_slot_ram #(
	parameter int DEPTH = xfec_pkg::FRAME_WORDS_DEF,
	parameter int AW    = 8
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [xfec_pkg::WORD_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [xfec_pkg::WORD_W-1:0] rd_data
);
	import xfec_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/xfec_ctrl.sv */
`include "xor_parity_fec_decoder_defines.svh"

module xfec_ctrl #(
	parameter int FRAME_WORDS = xfec_pkg::FRAME_WORDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  xfec_pkg::xfec_in_t   item,
	output xfec_pkg::xfec_ctrl_t ctrl
);
	import xfec_pkg::*;

	logic [DATA_SLOTS-1:0] mask_q, mask_d, mask_base;
	logic [GRP_W-1:0]      grp_q, grp_d, grp;
	logic [1:0]            outcome_q, outcome_d;
	logic [SLOT_W-1:0]     miss_q, miss_d;
	logic [CNT_W-1:0]      rec_q, rec_d, fail_q, fail_d;
	logic [SLOT_W-1:0]     slot, which, miss_cnt;
	logic                  first, in_range;

	always_comb begin
		slot      = item.seq_number[SLOT_W-1:0];
		grp       = item.seq_number[SEQ_W-1:SLOT_W];
		first     = item.word_index == '0;
		in_range  = 32'(item.word_index) < FRAME_WORDS;
		mask_base = (first && grp != grp_q) ? '0 : mask_q;

		miss_cnt = '0;
		which    = '0;
		for (int s = 0; s < DATA_SLOTS; s++) begin
			if (!mask_base[s]) begin
				miss_cnt = miss_cnt + SLOT_W'(1);
				which    = SLOT_W'(s);
			end
		end

		mask_d    = mask_q;
		grp_d     = grp_q;
		outcome_d = outcome_q;
		miss_d    = miss_q;
		rec_d     = rec_q;
		fail_d    = fail_q;

		ctrl.store   = 1'b0;
		ctrl.emit    = 1'b0;
		ctrl.rebuild = 1'b0;
		ctrl.status  = ST_PASS;
		ctrl.slot    = slot;
		ctrl.last    = 32'(item.word_index) == 32'(FRAME_WORDS - 1);

		if (in_range) begin
			if (first) begin
				grp_d = grp;
			end
			mask_d = mask_base;
			if (slot != PARITY_SLOT) begin
				mask_d     = mask_base | (DATA_SLOTS'(1) << slot);
				outcome_d  = OC_NONE;
				ctrl.store = 1'b1;
				ctrl.emit  = 1'b1;
			end else if (first) begin
				case (miss_cnt)
					SLOT_W'(0): begin
						outcome_d = OC_NONE;
					end
					SLOT_W'(1): begin
						outcome_d    = OC_REBUILD;
						miss_d       = which;
						rec_d        = rec_q + CNT_W'(1);
						ctrl.emit    = 1'b1;
						ctrl.rebuild = 1'b1;
						ctrl.status  = ST_REBUILT;
						ctrl.slot    = which;
					end
					default: begin
						outcome_d   = OC_FAIL;
						fail_d      = fail_q + CNT_W'(1);
						ctrl.emit   = 1'b1;
						ctrl.status = ST_FAIL;
						ctrl.slot   = '0;
						ctrl.last   = 1'b0;
					end
				endcase
			end else if (outcome_q == OC_REBUILD) begin
				ctrl.emit    = 1'b1;
				ctrl.rebuild = 1'b1;
				ctrl.status  = ST_REBUILT;
				ctrl.slot    = miss_q;
			end
		end

		ctrl.recovered = rec_d;
		ctrl.failed    = fail_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			grp_q     <= '0;
			outcome_q <= OC_NONE;
			miss_q    <= '0;
			rec_q     <= '0;
			fail_q    <= '0;
		end else if (accept) begin
			mask_q    <= mask_d;
			grp_q     <= grp_d;
			outcome_q <= outcome_d;
			miss_q    <= miss_d;
			rec_q     <= rec_d;
			fail_q    <= fail_d;
		end
	end

	`XFEC_ASSERT_NEXT(a_cnt_hold, clk, arst_n, !(accept && ctrl.emit), $stable(rec_q) && $stable(fail_q))
	`XFEC_ASSERT_NEXT(a_fail_latch, clk, arst_n, accept && ctrl.emit && ctrl.status == ST_FAIL, outcome_q == OC_FAIL)

endmodule

/* design/xor_parity_fec_decoder.sv */
// Channel  Handshake                    Word
// item     item_valid / item_ready      xfec_in_t  (seq_number, word_index, data_word)
// result   result_valid / result_ready  xfec_out_t (status, out_word, out_slot, out_last,
//                                                   recovered_total, failed_total)
//
// One word is taken every cycle while item_ready is high.
// Each result passes the registered read of the seven data slot banks, which all read
// the same index, followed by the output register where the rebuild XOR lands.
// Reset clears the receive mask, group, parity outcome and both counters; the slot
// banks need no clearing pass. A stalled result holds one more word in the read stage,
// after which item_ready drops until the result side drains.
`include "xor_parity_fec_decoder_defines.svh"

module xor_parity_fec_decoder #(
	parameter int FRAME_WORDS = xfec_pkg::FRAME_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  xfec_pkg::xfec_in_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output xfec_pkg::xfec_out_t result
);
	import xfec_pkg::*;

	localparam int AW = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;

	xfec_ctrl_t ctrl;
	logic       accept, adv_s2, move_s1;
	logic [AW-1:0] addr;

	logic                v_s1, rebuild_s1, last_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [WORD_W-1:0]   word_s1;
	logic [CNT_W-1:0]    rec_s1, fail_s1;

	logic [WORD_W-1:0] rd_data [DATA_SLOTS];
	logic [WORD_W-1:0] rebuilt;

	assign accept     = item_valid && item_ready;
	assign adv_s2     = !result_valid || result_ready;
	assign move_s1    = v_s1 && adv_s2;
	assign item_ready = !v_s1 || adv_s2;
	assign addr       = AW'(item.word_index);

	xfec_ctrl #(.FRAME_WORDS(FRAME_WORDS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.ctrl   (ctrl)
	);

	for (genvar b = 0; b < DATA_SLOTS; b++) begin : g_bank
		xfec_slot_ram #(.DEPTH(FRAME_WORDS), .AW(AW)) u_bank (
			.clk     (clk),
			.wr_en   (accept && ctrl.store && item.seq_number[SLOT_W-1:0] == SLOT_W'(b)),
			.wr_addr (addr),
			.wr_data (item.data_word),
			.rd_en   (accept),
			.rd_addr (addr),
			.rd_data (rd_data[b])
		);
	end

	// on a rebuild, fold in every data slot but the one being rebuilt
	always_comb begin
		rebuilt = word_s1;
		for (int s = 0; s < DATA_SLOTS; s++) begin
			if (rebuild_s1 && SLOT_W'(s) != slot_s1) begin
				rebuilt = rebuilt ^ rd_data[s];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= ctrl.emit;
		end else if (move_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rebuild_s1 <= ctrl.rebuild;
			status_s1  <= ctrl.status;
			slot_s1    <= ctrl.slot;
			last_s1    <= ctrl.last;
			word_s1    <= (ctrl.status == ST_FAIL) ? '0 : item.data_word;
			rec_s1     <= ctrl.recovered;
			fail_s1    <= ctrl.failed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (move_s1) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			result.status          <= status_s1;
			result.out_word        <= rebuilt;
			result.out_slot        <= slot_s1;
			result.out_last        <= last_s1;
			result.recovered_total <= rec_s1;
			result.failed_total    <= fail_s1;
		end
	end

	`XFEC_ASSERT_IMPL(a_stall_blocks, clk, arst_n, v_s1 && result_valid && !result_ready, !item_ready)
	`XFEC_ASSERT_NEXT(a_s1_drains, clk, arst_n, v_s1 && adv_s2, result_valid)
	`XFEC_ASSERT_IMPL(a_fail_blank, clk, arst_n, result_valid && result.status == ST_FAIL, result.out_word == '0 && result.out_slot == '0 && !result.out_last)

endmodule
